// ----- hdl/aclk_pkg.sv -----
// Types, codes and digit constants shared by the alarm clock modules.
// Depends on nothing.
`timescale 1ns / 1ps

package aclk_pkg;

  localparam int unsigned NUM_DIGITS = 6;
  localparam int unsigned DIGIT_W    = 4;

  typedef logic [DIGIT_W-1:0]    digit_t;
  typedef digit_t [NUM_DIGITS-1:0] digits_t;
  typedef logic [NUM_DIGITS-1:0]  digit_sel_t;

  // Digit positions in a count, least significant first.
  localparam int unsigned SEC_UNITS  = 0;
  localparam int unsigned SEC_TENS   = 1;
  localparam int unsigned MIN_UNITS  = 2;
  localparam int unsigned MIN_TENS   = 3;
  localparam int unsigned HOUR_UNITS = 4;
  localparam int unsigned HOUR_TENS  = 5;

  // Highest value of each digit before it wraps.
  localparam digit_t DEC_LAST        = digit_t'(9);
  localparam digit_t SEXA_LAST       = digit_t'(5);
  localparam digit_t HOUR_TENS_LAST  = digit_t'(2);
  localparam digit_t HOUR_UNITS_LATE = digit_t'(3);

  // Where an increment enters the digit chain.
  localparam digit_sel_t INC_NONE = digit_sel_t'(0);
  localparam digit_sel_t INC_SEC  = digit_sel_t'(1) << SEC_UNITS;
  localparam digit_sel_t INC_MIN  = digit_sel_t'(1) << MIN_UNITS;
  localparam digit_sel_t INC_HOUR = digit_sel_t'(1) << HOUR_UNITS;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_BUTTON = 1'b1;

  localparam logic [4:0] BTN_ADD_SEC   = 5'h01;
  localparam logic [4:0] BTN_ADD_MIN   = 5'h02;
  localparam logic [4:0] BTN_ADD_HOUR  = 5'h04;
  localparam logic [4:0] BTN_ALARM_OFF = 5'h07;
  localparam logic [4:0] BTN_ALARM_ON  = 5'h08;
  localparam logic [4:0] BTN_TIME_OFF  = 5'h09;
  localparam logic [4:0] BTN_TIME_ON   = 5'h10;

  typedef struct packed {
    logic       cmd;
    logic [4:0] button_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
    logic       alarm_beep;
  } out_item_t;

endpackage

// ----- hdl/aclk_digit_cell.sv -----
// One decimal digit of a time count with a carry to the next digit.
// Depends on aclk_pkg.
`timescale 1ns / 1ps

module aclk_digit_cell import aclk_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   inc_i,
  input  digit_t last_i,
  output digit_t digit_o,
  output digit_t digit_d_o,
  output logic   carry_o
);

  digit_t digit_q, digit_d;
  logic   at_last;

  assign at_last = (digit_q == last_i);
  assign carry_o = inc_i && at_last;

  always_comb begin
    digit_d = digit_q;
    if (inc_i) begin
      digit_d = at_last ? '0 : digit_q + digit_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign digit_o   = digit_q;
  assign digit_d_o = digit_d;

endmodule

// ----- hdl/aclk_digit_chain.sv -----
// Six digit cells that form an hh:mm:ss count with a 24-hour wrap.
// Depends on aclk_pkg and aclk_digit_cell.
`timescale 1ns / 1ps

module aclk_digit_chain import aclk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  digit_sel_t inc_i,
  output digits_t    digits_o,
  output digits_t    digits_d_o
);

  digit_t     last [NUM_DIGITS];
  digit_sel_t carry;

  always_comb begin
    last[SEC_UNITS]  = DEC_LAST;
    last[SEC_TENS]   = SEXA_LAST;
    last[MIN_UNITS]  = DEC_LAST;
    last[MIN_TENS]   = SEXA_LAST;
    last[HOUR_UNITS] = (digits_o[HOUR_TENS] == HOUR_TENS_LAST) ? HOUR_UNITS_LATE : DEC_LAST;
    last[HOUR_TENS]  = HOUR_TENS_LAST;
  end

  assign carry[0] = 1'b0;

  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    if (g < NUM_DIGITS - 1) begin : g_mid
      aclk_digit_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .inc_i     (inc_i[g] | carry[g]),
        .last_i    (last[g]),
        .digit_o   (digits_o[g]),
        .digit_d_o (digits_d_o[g]),
        .carry_o   (carry[g+1])
      );
    end else begin : g_end
      aclk_digit_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .inc_i     (inc_i[g] | carry[g]),
        .last_i    (last[g]),
        .digit_o   (digits_o[g]),
        .digit_d_o (digits_d_o[g]),
        .carry_o   ()
      );
    end
  end

endmodule

// ----- hdl/alarm_clock_with_time_set_unit.sv -----
// Top level of the 24-hour alarm clock with time-set and alarm-set modes.
// Depends on aclk_pkg and aclk_digit_chain.
`timescale 1ns / 1ps

// The block takes one tick or button transfer in every cycle while in_stall_o
// is low and gives one registered result per transfer. Time and alarm are kept
// as two chains of six decimal digit cells; the carry ripple through one chain
// and the compare against the alarm digits set the longest path. A two-entry
// output stage lets a new transfer in while a result waits to be taken.
module alarm_clock_with_time_set_unit import aclk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic       accept;
  logic       time_mode_q, time_mode_d;
  logic       alarm_mode_q, alarm_mode_d;
  digit_sel_t time_inc, alarm_inc, step_sel;
  digits_t    time_next;
  digits_t    alarm_digits, alarm_next;
  digits_t    shown_q, shown_d;
  logic       show_time, show_alarm, beep;
  out_item_t  result;
  out_item_t  out_q, skid_q;
  logic       out_valid_q, skid_valid_q;
  logic       out_free;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !in_stall_o;

  aclk_digit_chain u_time (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .inc_i      (time_inc),
    .digits_o   (),
    .digits_d_o (time_next)
  );

  aclk_digit_chain u_alarm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .inc_i      (alarm_inc),
    .digits_o   (alarm_digits),
    .digits_d_o (alarm_next)
  );

  always_comb begin
    case (in_data_i.button_code)
      BTN_ADD_SEC:  step_sel = INC_SEC;
      BTN_ADD_MIN:  step_sel = INC_MIN;
      BTN_ADD_HOUR: step_sel = INC_HOUR;
      default:      step_sel = INC_NONE;
    endcase
  end

  always_comb begin
    time_mode_d  = time_mode_q;
    alarm_mode_d = alarm_mode_q;
    time_inc     = INC_NONE;
    alarm_inc    = INC_NONE;
    show_time    = 1'b0;
    show_alarm   = 1'b0;
    beep         = 1'b0;
    if (accept) begin
      if (in_data_i.cmd == CMD_TICK) begin
        if (!time_mode_q && !alarm_mode_q) begin
          time_inc  = INC_SEC;
          show_time = 1'b1;
          beep      = (time_next == alarm_digits);
        end
      end else begin
        case (in_data_i.button_code)
          BTN_TIME_ON:   time_mode_d  = 1'b1;
          BTN_TIME_OFF:  time_mode_d  = 1'b0;
          BTN_ALARM_ON:  alarm_mode_d = 1'b1;
          BTN_ALARM_OFF: alarm_mode_d = 1'b0;
          default:       ;
        endcase
        if (time_mode_d) begin
          time_inc  = step_sel;
          show_time = 1'b1;
        end
        if (alarm_mode_d) begin
          alarm_inc  = step_sel;
          show_alarm = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (show_alarm) begin
      shown_d = alarm_next;
    end else if (show_time) begin
      shown_d = time_next;
    end else begin
      shown_d = shown_q;
    end
  end

  always_comb begin
    result.hour_tens    = shown_d[HOUR_TENS][1:0];
    result.hour_units   = shown_d[HOUR_UNITS];
    result.minute_tens  = shown_d[MIN_TENS][2:0];
    result.minute_units = shown_d[MIN_UNITS];
    result.second_tens  = shown_d[SEC_TENS][2:0];
    result.second_units = shown_d[SEC_UNITS];
    result.alarm_beep   = beep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_mode_q  <= 1'b0;
      alarm_mode_q <= 1'b0;
      shown_q      <= '0;
    end else begin
      time_mode_q  <= time_mode_d;
      alarm_mode_q <= alarm_mode_d;
      shown_q      <= shown_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= accept;
      end else begin
        out_valid_q  <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (accept) begin
          skid_q <= result;
        end
      end else if (accept) begin
        out_q <= result;
      end
    end else if (accept) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
